@@ hdl/cvfj_pkg.sv @@
// Package: shared constants, types and fixed-point helpers for the cubic vector field unit
`default_nettype none
package cvfj_pkg;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int NTERMS         = 19;
  localparam int NCOEF          = 57;
  localparam int IDX_W          = 6;
  localparam int VW             = 48;
  localparam int POS_W          = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;

  localparam logic signed [VW-1:0] SAT_POS = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_NEG = {1'b1, {(VW-1){1'b0}}};

  typedef logic signed [VW-1:0] val_t;
  typedef val_t vec12_t [12];
  typedef val_t mono_t [20];

  // Saturate a wide sum to 48 bits
  function automatic val_t sat_w(input logic signed [55:0] v);
    if (v > 56'sh007FFFFFFFFFFF) return SAT_POS;
    if (v < -56'sh00800000000000) return SAT_NEG;
    return v[VW-1:0];
  endfunction
endpackage
`default_nettype wire

@@ hdl/cvfj_fmul.sv @@
// Module: pipelined fixed-point multiply, floor shift and 48-bit saturate (two register stages)
`default_nettype none
module cvfj_fmul #(
  parameter int FRAC_BITS = cvfj_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              en,
  input  wire  logic signed [cvfj_pkg::VW-1:0] a,
  input  wire  logic signed [cvfj_pkg::VW-1:0] b,
  output logic signed [cvfj_pkg::VW-1:0]       p
);
  import cvfj_pkg::*;
  localparam int PW   = 2 * VW;
  localparam int HW   = VW / 2;
  localparam int PPW  = 2 * HW;
  localparam int PPW1 = 2 * HW + 1;

  logic signed [HW-1:0]   ah, bh;
  logic signed [HW:0]     al, bl;
  logic signed [PPW-1:0]  hh_r;
  logic signed [PPW1-1:0] hl_r, lh_r, ll_r;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   shf;

  // Split operands into signed upper and unsigned lower halves
  assign ah = a[VW-1:HW];
  assign bh = b[VW-1:HW];
  assign al = {1'b0, a[HW-1:0]};
  assign bl = {1'b0, b[HW-1:0]};

  // Register the four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= PPW'(ah) * PPW'(bh);
      hl_r <= PPW1'(ah) * PPW1'(bl);
      lh_r <= PPW1'(al) * PPW1'(bh);
      ll_r <= PPW1'(al) * PPW1'(bl);
    end
  end

  // Combine partials; arithmetic shift is the floor
  always_comb begin
    prod = (PW'(hh_r) <<< PPW) + (PW'(hl_r) <<< HW) + (PW'(lh_r) <<< HW) + PW'(ll_r);
    shf  = prod >>> FRAC_BITS;
  end

  // Saturate to 48 bits and register
  always_ff @(posedge clk) begin
    if (en) begin
      if (shf > PW'(SAT_POS)) p <= SAT_POS;
      else if (shf < PW'(SAT_NEG)) p <= SAT_NEG;
      else p <= shf[VW-1:0];
    end
  end
endmodule
`default_nettype wire

@@ hdl/cvfj_datapath.sv @@
// Module: monomial and accumulation pipeline stages
`default_nettype none
module cvfj_datapath #(
  parameter int FRAC_BITS  = cvfj_pkg::FRAC_BITS_DEF,
  parameter int COEF_WIDTH = cvfj_pkg::COEF_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               en,
  input  wire  logic signed [32:0]          off_x,
  input  wire  logic signed [32:0]          off_y,
  input  wire  logic signed [32:0]          off_z,
  input  wire  logic [3*cvfj_pkg::NTERMS*COEF_WIDTH-1:0] coefs,
  output cvfj_pkg::vec12_t                  res
);
  import cvfj_pkg::*;
  localparam int NC = 3 * NTERMS;
  localparam int ND = 90;

  // Stage group A: second-order monomials
  val_t xv, yv, zv;
  val_t q [6];
  val_t q_in_a [6], q_in_b [6];
  assign xv = VW'(off_x);
  assign yv = VW'(off_y);
  assign zv = VW'(off_z);
  assign q_in_a = '{xv, yv, zv, xv, xv, yv};
  assign q_in_b = '{xv, yv, zv, yv, zv, zv};

  genvar g;
  generate
    for (g = 0; g < 6; g++) begin : g_sq
      cvfj_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .en(en), .a(q_in_a[g]), .b(q_in_b[g]), .p(q[g]));
    end
  endgenerate

  // Delay offsets and coefficients alongside
  val_t x1_r, y1_r, z1_r, x2_r, y2_r, z2_r, x3_r, y3_r, z3_r, x4_r, y4_r, z4_r;
  val_t q3_r [6], q4_r [6];
  logic [NC*COEF_WIDTH-1:0] k1_r, k2_r, k3_r, k4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= xv;   y1_r <= yv;   z1_r <= zv;
      x2_r <= x1_r; y2_r <= y1_r; z2_r <= z1_r;
      x3_r <= x2_r; y3_r <= y2_r; z3_r <= z2_r;
      x4_r <= x3_r; y4_r <= y3_r; z4_r <= z3_r;
      q3_r <= q;    q4_r <= q3_r;
      k1_r <= coefs; k2_r <= k1_r; k3_r <= k2_r; k4_r <= k3_r;
    end
  end

  // Stage group B: cubic monomials (xx,yy,zz,xy,xz,yz = q0..q5)
  val_t c [10];
  val_t c_a [10], c_b [10];
  assign c_a = '{q[0], q[1], q[2], q[0], q[0], q[3], q[1], q[4], q[5], q[3]};
  assign c_b = '{x2_r, y2_r, z2_r, y2_r, z2_r, y2_r, z2_r, z2_r, z2_r, z2_r};
  generate
    for (g = 0; g < 10; g++) begin : g_cu
      cvfj_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .en(en), .a(c_a[g]), .b(c_b[g]), .p(c[g]));
    end
  endgenerate

  // Monomial vector, index 19 is one
  mono_t m;
  always_comb begin
    for (int i = 0; i < 10; i++) m[i] = c[i];
    for (int i = 0; i < 6; i++) m[10+i] = q4_r[i];
    m[16] = x4_r; m[17] = y4_r; m[18] = z4_r;
    m[19] = VW'(1) <<< FRAC_BITS;
  end

  // Derivative term table: coefficient, monomial, weight per axis
  localparam int DC [3][10] = '{
    '{0, 3, 4, 5, 7, 9, 10, 13, 14, 16},
    '{1, 5, 6, 3, 8, 9, 11, 13, 15, 17},
    '{2, 7, 8, 4, 6, 9, 12, 14, 15, 18}};
  localparam int DM [3][10] = '{
    '{10, 13, 14, 11, 12, 15, 16, 17, 18, 19},
    '{11, 13, 15, 10, 12, 14, 17, 16, 18, 19},
    '{12, 14, 15, 10, 11, 13, 18, 16, 17, 19}};
  localparam int DW [10] = '{3, 2, 2, 1, 1, 1, 2, 1, 1, 1};

  // Stage group C: coefficient times monomial, 57 velocity lanes
  val_t kp [NC];
  val_t kv [NC];
  val_t mv [NC];
  generate
    for (g = 0; g < NC; g++) begin : g_km
      assign kv[g] = VW'($signed(k4_r[g*COEF_WIDTH +: COEF_WIDTH]));
      assign mv[g] = m[g % NTERMS];
      cvfj_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .en(en), .a(kv[g]), .b(mv[g]), .p(kp[g]));
    end
  endgenerate

  // Stage group C: coefficient times derivative monomial, 90 lanes
  val_t kd [ND];
  val_t kdv [ND];
  val_t mdv [ND];
  generate
    for (g = 0; g < ND; g++) begin : g_kd
      localparam int CC = g / 30;
      localparam int AX = (g / 10) % 3;
      localparam int TT = g % 10;
      assign kdv[g] = VW'($signed(k4_r[(CC*NTERMS+DC[AX][TT])*COEF_WIDTH +: COEF_WIDTH]));
      assign mdv[g] = m[DM[AX][TT]];
      cvfj_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .en(en), .a(kdv[g]), .b(mdv[g]), .p(kd[g]));
    end
  endgenerate

  // Stage D: weighted products, registered
  logic signed [55:0] wt_r [3][3][10];
  logic signed [55:0] vt_r [3][NTERMS];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int cc = 0; cc < 3; cc++) begin
        for (int t = 0; t < NTERMS; t++) vt_r[cc][t] <= 56'(kp[cc*NTERMS+t]);
        for (int ax = 0; ax < 3; ax++)
          for (int t = 0; t < 10; t++)
            wt_r[cc][ax][t] <= 56'(kd[cc*30+ax*10+t]) * 56'(DW[t]);
      end
    end
  end

  // Stage E: partial sums in groups of up to five
  logic signed [55:0] vs_r [3][4];
  logic signed [55:0] ws_r [3][3][2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int cc = 0; cc < 3; cc++) begin
        vs_r[cc][0] <= vt_r[cc][0] + vt_r[cc][1] + vt_r[cc][2] + vt_r[cc][3] + vt_r[cc][4];
        vs_r[cc][1] <= vt_r[cc][5] + vt_r[cc][6] + vt_r[cc][7] + vt_r[cc][8] + vt_r[cc][9];
        vs_r[cc][2] <= vt_r[cc][10] + vt_r[cc][11] + vt_r[cc][12] + vt_r[cc][13]
                       + vt_r[cc][14];
        vs_r[cc][3] <= vt_r[cc][15] + vt_r[cc][16] + vt_r[cc][17] + vt_r[cc][18];
        for (int ax = 0; ax < 3; ax++) begin
          ws_r[cc][ax][0] <= wt_r[cc][ax][0] + wt_r[cc][ax][1] + wt_r[cc][ax][2]
                             + wt_r[cc][ax][3] + wt_r[cc][ax][4];
          ws_r[cc][ax][1] <= wt_r[cc][ax][5] + wt_r[cc][ax][6] + wt_r[cc][ax][7]
                             + wt_r[cc][ax][8] + wt_r[cc][ax][9];
        end
      end
    end
  end

  // Stage F: final add and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int cc = 0; cc < 3; cc++) begin
        res[cc] <= sat_w(vs_r[cc][0] + vs_r[cc][1] + vs_r[cc][2] + vs_r[cc][3]);
        for (int ax = 0; ax < 3; ax++)
          res[3+cc*3+ax] <= sat_w(ws_r[cc][ax][0] + ws_r[cc][ax][1]);
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/cubic_vector_field_with_jacobian_unit.sv @@
// Top level: cubic vector field evaluator with Jacobian, streaming ports
//
//  channel | dir | fields
//  in_     | in  | tdata: coef_component, coef_index, coef_value, pos_x/y/z; tuser: command
//  out_    | out | tdata: vel_x..vel_z, dvx_dx..dvz_dz (48 bits each)
//  cfg_    | in  | index 0..2 origin_x/y/z, data 32 bits
//
//  One request per cycle while the output is not stalled; the pipeline is the origin subtract,
//  the chain of three multiply stages and three adder/saturation stages behind them.
//  Reset clears the origin registers and the coefficient table.
//  A stall on the output freezes the whole pipeline; nothing is lost or repeated.
//  Loads write the table in the accept cycle and produce no result.
`default_nettype none
module cubic_vector_field_with_jacobian_unit #(
  parameter int FRAC_BITS  = cvfj_pkg::FRAC_BITS_DEF,
  parameter int COEF_WIDTH = cvfj_pkg::COEF_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // tdata from bit 0: coef_component[1:0], coef_index[6:2], coef_value[38:7],
  // pos_x[70:39], pos_y[102:71], pos_z[134:103], zero fill to 136
  input  wire  [135:0] in_tdata,
  // tuser: command
  input  wire  [0:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // tdata from bit 0: vel_x, vel_y, vel_z, dvx_dx, dvx_dy, dvx_dz, dvy_dx, dvy_dy,
  // dvy_dz, dvz_dx, dvz_dy, dvz_dz, 48 bits each
  output logic [575:0] out_tdata,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [31:0]  cfg_data
);
  import cvfj_pkg::*;
  localparam int NC  = 3 * NTERMS;
  localparam int LAT = 10;

  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic signed [COEF_WIDTH-1:0] coef_r [NC];
  logic [NC*COEF_WIDTH-1:0] coef_flat;
  logic [LAT-1:0] vld_r;
  logic en;

  logic [1:0] comp;
  logic [4:0] idx;
  logic signed [31:0] cval;
  logic signed [COEF_WIDTH-1:0] csat;
  logic [IDX_W-1:0] waddr;

  assign comp = in_tdata[1:0];
  assign idx  = in_tdata[6:2];
  assign cval = in_tdata[38:7];
  assign waddr = IDX_W'(comp) * IDX_W'(NTERMS) + IDX_W'(idx);

  // Saturate a loaded value to the coefficient width
  always_comb begin
    logic signed [63:0] w, hi, lo;
    w  = 64'(cval);
    hi = (64'sd1 <<< (COEF_WIDTH-1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (w > hi) csat = hi[COEF_WIDTH-1:0];
    else if (w < lo) csat = lo[COEF_WIDTH-1:0];
    else csat = w[COEF_WIDTH-1:0];
  end

  // Pipeline advances whenever the output slot is free
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign out_tvalid = vld_r[LAT-1];

  // Origin registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: org_x_r <= cfg_data;
        CFG_ORIGIN_Y: org_y_r <= cfg_data;
        CFG_ORIGIN_Z: org_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Coefficient table, cleared at reset, one load per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) coef_r[i] <= '0;
    end else if (in_tvalid && in_tready && in_tuser[0] == CMD_LOAD
                 && comp != 2'd3 && idx < 5'(NTERMS)) begin
      coef_r[waddr] <= csat;
    end
  end

  always_comb
    for (int i = 0; i < NC; i++) coef_flat[i*COEF_WIDTH +: COEF_WIDTH] = coef_r[i];

  // Origin subtract stage
  logic signed [32:0] ox_r, oy_r, oz_r;
  logic [NC*COEF_WIDTH-1:0] k0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= 33'(signed'(in_tdata[70:39]))  - 33'(org_x_r);
      oy_r <= 33'(signed'(in_tdata[102:71])) - 33'(org_y_r);
      oz_r <= 33'(signed'(in_tdata[134:103])) - 33'(org_z_r);
      k0_r <= coef_flat;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid && in_tuser[0] == CMD_EVAL};
  end

  vec12_t res;
  cvfj_datapath #(.FRAC_BITS(FRAC_BITS), .COEF_WIDTH(COEF_WIDTH)) u_dp (
    .clk(clk), .en(en), .off_x(ox_r), .off_y(oy_r), .off_z(oz_r),
    .coefs(k0_r), .res(res));

  always_comb
    for (int i = 0; i < 12; i++) out_tdata[i*VW +: VW] = res[i];

  // Output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken during stall");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == CMD_LOAD |=> !vld_r[0])
    else $error("load produced result");
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for the cubic vector field unit: directed and random requests, self-checking
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cvfj_pkg::*;

  localparam int LATENCY = 10;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [575:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cubic_vector_field_with_jacobian_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic signed [63:0] org [3];
  logic signed [63:0] coef_tab [57];
  logic [575:0] field_q [$];

  int mismatches = 0;
  int results_seen = 0;
  int evals_sent = 0;
  int loads_sent = 0;
  bit hold_off = 1'b0;
  bit no_gaps = 1'b0;

  // floor(a*b / 2^16) saturated to 48 bits
  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = 128'(a) * 128'(b);
    q = p >>> 16;
    if (q > 128'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
    if (q < -128'sh800000000000) return -64'sh800000000000;
    return q[63:0];
  endfunction

  function automatic logic [47:0] clip48(logic signed [63:0] v);
    if (v > 64'sh7FFFFFFFFFFF) return 48'h7FFFFFFFFFFF;
    if (v < -64'sh800000000000) return 48'h800000000000;
    return v[47:0];
  endfunction

  // Velocity and Jacobian for one position
  function automatic logic [575:0] field_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    logic signed [63:0] m [20];
    logic signed [63:0] x, y, z, acc;
    logic [575:0] r;
    int k;
    // per axis: coefficient, monomial, weight
    int dt [3][10][3] = '{
      '{'{0,10,3},'{3,13,2},'{4,14,2},'{5,11,1},'{7,12,1},'{9,15,1},'{10,16,2},'{13,17,1},
        '{14,18,1},'{16,19,1}},
      '{'{1,11,3},'{5,13,2},'{6,15,2},'{3,10,1},'{8,12,1},'{9,14,1},'{11,17,2},'{13,16,1},
        '{15,18,1},'{17,19,1}},
      '{'{2,12,3},'{7,14,2},'{8,15,2},'{4,10,1},'{6,11,1},'{9,13,1},'{12,18,2},'{14,16,1},
        '{15,17,1},'{18,19,1}}};
    x = 64'($signed(px)) - org[0];
    y = 64'($signed(py)) - org[1];
    z = 64'($signed(pz)) - org[2];
    m[16] = x; m[17] = y; m[18] = z;
    m[10] = qmul(x, x); m[11] = qmul(y, y); m[12] = qmul(z, z);
    m[13] = qmul(x, y); m[14] = qmul(x, z); m[15] = qmul(y, z);
    m[0] = qmul(m[10], x); m[1] = qmul(m[11], y); m[2] = qmul(m[12], z);
    m[3] = qmul(m[10], y); m[4] = qmul(m[10], z); m[5] = qmul(m[13], y);
    m[6] = qmul(m[11], z); m[7] = qmul(m[14], z); m[8] = qmul(m[15], z);
    m[9] = qmul(m[13], z);
    m[19] = 64'sd65536;
    r = '0;
    for (int c = 0; c < 3; c++) begin
      k = c * 19;
      acc = 0;
      for (int t = 0; t < 19; t++) acc += qmul(coef_tab[k + t], m[t]);
      r[c*48 +: 48] = clip48(acc);
      for (int a = 0; a < 3; a++) begin
        acc = 0;
        for (int t = 0; t < 10; t++)
          acc += dt[a][t][2] * qmul(coef_tab[k + dt[a][t][0]], m[dt[a][t][1]]);
        r[(3 + c*3 + a)*48 +: 48] = clip48(acc);
      end
    end
    return r;
  endfunction

  // Random gap: mostly none or short, a few long; drop valid during a gap
  task automatic random_gap();
    int n;
    int r;
    r = $urandom_range(99);
    n = (no_gaps || r < 55) ? 0 : (r < 93 ? $urandom_range(3, 1) : $urandom_range(30, 8));
    if (n > 0) in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send one request and update the predictor when accepted
  task automatic send_item(logic cmd, logic [1:0] comp, logic [4:0] idx, logic [31:0] val,
                           logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    if (cfg_valid) cfg_valid <= 1'b0;
    random_gap();
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {1'b0, pz, py, px, val, idx, comp};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_LOAD) begin
      loads_sent++;
      if (comp < 3 && idx < 19) coef_tab[comp*19 + idx] = 64'($signed(val));
    end else begin
      evals_sent++;
      field_q.push_back(field_at(px, py, pz));
    end
  endtask

  task automatic write_origin(logic [1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_ORIGIN_Z) org[idx] = 64'($signed(v));
  endtask

  // Drain all results, then let loads settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (field_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2000)) - 1000) << 16;
      3: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_all_random();
    for (int c = 0; c < 3; c++)
      for (int t = 0; t < 19; t++)
        send_item(CMD_LOAD, c[1:0], t[4:0], rnd_word(), '0, '0, '0);
  endtask

  task automatic test_directed();
    // zero table gives zero output
    send_item(CMD_EVAL, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000);
    // single linear term, then extreme values on cubic and linear terms
    send_item(CMD_LOAD, 0, 16, 32'h00010000, 0, 0, 0);
    send_item(CMD_LOAD, 1, 1, 32'h7FFFFFFF, 0, 0, 0);
    send_item(CMD_LOAD, 2, 18, 32'h80000000, 0, 0, 0);
    send_item(CMD_LOAD, 2, 9, 32'hFFFFFFFF, 0, 0, 0);
    // bad addresses are dropped
    send_item(CMD_LOAD, 3, 5, 32'h12345678, 0, 0, 0);
    send_item(CMD_LOAD, 0, 19, 32'h12345678, 0, 0, 0);
    send_item(CMD_LOAD, 1, 31, 32'hFFFFFFFF, 0, 0, 0);
    send_item(CMD_EVAL, 0, 0, 0, 32'h00020000, 32'hFFFF0000, 32'h00008000);
    send_item(CMD_EVAL, 3, 31, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(CMD_EVAL, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(CMD_EVAL, 0, 0, 0, 32'h00000001, 32'hFFFFFFFF, 32'h00000000);
    wait_idle();
  endtask

  task automatic test_origin_extremes();
    write_origin(CFG_ORIGIN_X, 32'h80000000);
    write_origin(CFG_ORIGIN_Y, 32'h7FFFFFFF);
    write_origin(CFG_ORIGIN_Z, 32'hFFFF0000);
    send_item(CMD_EVAL, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000);
    send_item(CMD_EVAL, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000);
    wait_idle();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25)
        send_item(CMD_LOAD, 2'($urandom_range(2)), 5'($urandom_range(18)), rnd_word(),
                  $urandom, $urandom, $urandom);
      else if (r < 28)
        send_item(CMD_LOAD, 2'($urandom), 5'($urandom), $urandom, $urandom, $urandom,
                  $urandom);
      else
        send_item(CMD_EVAL, 2'($urandom), 5'($urandom), $urandom, rnd_word(), rnd_word(),
                  rnd_word());
    end
  endtask

  // Random phases across several origin settings
  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        write_origin(CFG_ORIGIN_X, 0);
        write_origin(CFG_ORIGIN_Y, 0);
        write_origin(CFG_ORIGIN_Z, 0);
      end else begin
        write_origin(CFG_ORIGIN_X, rnd_word());
        write_origin(CFG_ORIGIN_Y, rnd_word());
        write_origin(CFG_ORIGIN_Z, rnd_word());
        write_origin(2'd3, $urandom);
      end
      no_gaps = (ph == 2);
      load_all_random();
      test_random(278);
      wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  // Stall the output long enough to back up the pipeline
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        no_gaps = 1'b1;
        for (int i = 0; i < 60; i++)
          send_item(CMD_EVAL, 0, 0, 0, rnd_word(), rnd_word(), rnd_word());
        no_gaps = 1'b0;
      end
    join
    wait_idle();
  endtask

  // Output ready: random stalls, or held low on request
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(9) < 7);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (field_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request pending");
      end else begin
        logic [575:0] want;
        want = field_q.pop_front();
        for (int f = 0; f < 12; f++)
          if (out_tdata[f*48 +: 48] !== want[f*48 +: 48]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d field %0d expected %h got %h",
                       results_seen, f, want[f*48 +: 48], out_tdata[f*48 +: 48]);
          end
      end
    end
  end

  // Watchdog on cycles with no handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", field_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) org[i] = 0;
    for (int i = 0; i < 57; i++) coef_tab[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_origin_extremes();
    test_random_phases();
    test_backpressure();
    if (field_q.size() != 0) mismatches += field_q.size();
    $display("covered %0d loads and %0d evaluations, %0d results checked",
             loads_sent, evals_sent, results_seen);
    $display("origin extremes, bad load addresses, output stalls and a long hold-off included");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
